/* rtl/mmsd_pkg.sv */
// ---------------------------------------------------------------------------
// mmsd_pkg: shared types and constants for the statistics block
// Field widths, shared-unit opcodes and step counts, and the structs that
// carry the running statistics and the shared-unit control.
// ---------------------------------------------------------------------------
package mmsd_pkg;

   // Field and accumulator widths
   localparam int SAMPLE_W = 16;
   localparam int COUNT_W  = 11;
   localparam int SUM_W    = 27;
   localparam int SUMSQ_W  = 41;
   localparam int SQUARE_W = 31;
   localparam int NN_W     = 21;
   localparam int VAR_W    = 32;

   // Shared unit datapath width and step counter width
   localparam int DP_W     = 54;
   localparam int STEP_W   = 6;
   localparam int ROOT_SHIFT = DP_W - VAR_W;

   // Shared unit opcodes
   typedef logic [1:0] iter_op_type;
   localparam iter_op_type OP_MUL  = 2'd0;
   localparam iter_op_type OP_DIV  = 2'd1;
   localparam iter_op_type OP_SQRT = 2'd2;

   // Step counts per operation
   localparam logic [STEP_W-1:0] MUL_N_STEPS   = 6'd11;
   localparam logic [STEP_W-1:0] MUL_SUM_STEPS = 6'd26;
   localparam logic [STEP_W-1:0] DIV_STEPS     = 6'd54;
   localparam logic [STEP_W-1:0] SQRT_STEPS    = 6'd16;

   // Command into the shared unit
   typedef struct packed {
      logic              start;
      iter_op_type       op;
      logic [STEP_W-1:0] steps;
   } iter_cmd_type;

   // Status out of the shared unit
   typedef struct packed {
      logic busy;
      logic done;
   } iter_sts_type;

   // Running statistics of the current set
   typedef struct packed {
      logic [COUNT_W-1:0]         count;
      logic signed [SAMPLE_W-1:0] max_value;
      logic signed [SAMPLE_W-1:0] min_value;
      logic signed [SUM_W-1:0]    sum;
      logic [SUMSQ_W-1:0]         sumsq;
      logic                       overflow;
   } stats_type;

endpackage

/* rtl/min_max_mean_stddev.sv */
// A sample that is not last is accepted in S_IDLE, accumulated in S_ACC, and
// only then is the next taken. The last sample of a set reaches rsp_valid
// after two 54-step divides, a 16-step root and multiplies of 11, 26 and 11
// steps on the shared unit, each operation with its own issue and handover.
// The handover waits while the output register is held; the next set follows it.
// Reset (synchronous, active high) clears all statistics and the sequencer.
// ---------------------------------------------------------------------------
// min_max_mean_stddev: streaming min, max, mean and standard deviation
// Accumulates signed Q8.8 samples and, on the last one, derives the mean and
// population deviation with a shared iterative unit, then clears the set.
// ---------------------------------------------------------------------------
module min_max_mean_stddev import mmsd_pkg::*; #(
   parameter int MAX_COUNT = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_max_value,
   output logic signed [SAMPLE_W-1:0] rsp_min_value,
   output logic signed [SAMPLE_W-1:0] rsp_mean_value,
   output logic [SAMPLE_W-1:0]        rsp_std_dev,
   output logic [COUNT_W-1:0]         rsp_sample_count,
   output logic                       rsp_overflow
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_ACC  = 4'd1;
   localparam logic [3:0] S_MEAN = 4'd2;
   localparam logic [3:0] S_NSQ  = 4'd3;
   localparam logic [3:0] S_SQ   = 4'd4;
   localparam logic [3:0] S_NN   = 4'd5;
   localparam logic [3:0] S_VAR  = 4'd6;
   localparam logic [3:0] S_ROOT = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic                issued_ff, issued_in;
   logic                last_ff, last_in;
   logic [DP_W-1:0]     num_ff, num_in;
   logic [DP_W-1:0]     diff_ff, diff_in;
   logic [NN_W-1:0]     nn_ff, nn_in;
   logic [VAR_W-1:0]    var_ff, var_in;
   logic [SAMPLE_W-1:0] mean_ff, mean_in;
   logic [SAMPLE_W-1:0] sd_ff, sd_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_load;
   logic signed [SAMPLE_W-1:0] rsp_max_ff, rsp_min_ff, rsp_mean_ff;
   logic [SAMPLE_W-1:0] rsp_sd_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_ovf_ff;

   logic                acc_load, acc_clear;
   stats_type           stats;
   iter_cmd_type        cmd;
   iter_sts_type        sts;
   logic [DP_W-1:0]     opa_init, opb_init, result;
   logic [SUM_W-1:0]    abs_sum;
   logic [DP_W-1:0]     abs_sum_ext, n_ext;
   logic [SAMPLE_W:0]   quot;
   logic [SAMPLE_W:0]   quot_neg;

   mmsd_accum #(.MAX_COUNT(MAX_COUNT)) u_accum (
      .clock  (clock),
      .reset  (reset),
      .load   (acc_load),
      .sample (req_sample),
      .clear  (acc_clear),
      .stats  (stats)
   );

   mmsd_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .opa_init (opa_init),
      .opb_init (opb_init),
      .sts      (sts),
      .result   (result)
   );

   // Operand preparation
   assign abs_sum     = stats.sum[SUM_W-1] ? (~stats.sum + 1'b1) : stats.sum;
   assign abs_sum_ext = {{(DP_W-SUM_W){1'b0}}, abs_sum};
   assign n_ext       = {{(DP_W-COUNT_W){1'b0}}, stats.count};
   assign quot        = result[SAMPLE_W:0];
   assign quot_neg    = ~quot + 1'b1;

   // Sequence the accumulation and the final computation
   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      last_in   = last_ff;
      num_in    = num_ff;
      diff_in   = diff_ff;
      nn_in     = nn_ff;
      var_in    = var_ff;
      mean_in   = mean_ff;
      sd_in     = sd_ff;
      req_ready = 1'b0;
      acc_load  = 1'b0;
      acc_clear = 1'b0;
      rsp_load  = 1'b0;
      cmd       = '0;
      opa_init  = '0;
      opb_init  = '0;

      // Operands and opcode of the current step
      case (state_ff)
         S_MEAN: begin
            cmd.op = OP_DIV;  cmd.steps = DIV_STEPS;
            opa_init = abs_sum_ext; opb_init = n_ext;
         end
         S_NSQ: begin
            cmd.op = OP_MUL;  cmd.steps = MUL_N_STEPS;
            opa_init = {{(DP_W-SUMSQ_W){1'b0}}, stats.sumsq}; opb_init = n_ext;
         end
         S_SQ: begin
            cmd.op = OP_MUL;  cmd.steps = MUL_SUM_STEPS;
            opa_init = abs_sum_ext; opb_init = abs_sum_ext;
         end
         S_NN: begin
            cmd.op = OP_MUL;  cmd.steps = MUL_N_STEPS;
            opa_init = n_ext; opb_init = n_ext;
         end
         S_VAR: begin
            cmd.op = OP_DIV;  cmd.steps = DIV_STEPS;
            opa_init = diff_ff; opb_init = {{(DP_W-NN_W){1'b0}}, nn_ff};
         end
         S_ROOT: begin
            cmd.op = OP_SQRT; cmd.steps = SQRT_STEPS;
            opa_init = {var_ff, {ROOT_SHIFT{1'b0}}};
         end
         default: begin
            cmd.op = OP_MUL;  cmd.steps = '0;
         end
      endcase

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               acc_load = 1'b1;
               last_in  = req_last;
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            state_in = last_ff ? S_MEAN : S_IDLE;
         end
         S_MEAN, S_NSQ, S_SQ, S_NN, S_VAR, S_ROOT: begin
            if (!issued_ff) begin
               cmd.start = 1'b1;
               issued_in = 1'b1;
            end else if (sts.done) begin
               issued_in = 1'b0;
               case (state_ff)
                  S_MEAN: begin
                     mean_in  = stats.sum[SUM_W-1] ? quot_neg[SAMPLE_W-1:0]
                                                   : quot[SAMPLE_W-1:0];
                     state_in = S_NSQ;
                  end
                  S_NSQ: begin
                     num_in   = result;
                     state_in = S_SQ;
                  end
                  S_SQ: begin
                     diff_in  = (num_ff > result) ? (num_ff - result) : '0;
                     state_in = S_NN;
                  end
                  S_NN: begin
                     nn_in    = result[NN_W-1:0];
                     state_in = S_VAR;
                  end
                  S_VAR: begin
                     var_in   = result[VAR_W-1:0];
                     state_in = S_ROOT;
                  end
                  default: begin
                     sd_in    = result[SAMPLE_W-1:0];
                     state_in = S_OUT;
                  end
               endcase
            end
         end
         S_OUT: begin
            // Hand the result over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load  = 1'b1;
               acc_clear = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      diff_ff <= diff_in;
      nn_ff   <= nn_in;
      var_ff  <= var_in;
      mean_ff <= mean_in;
      sd_ff   <= sd_in;
   end

   // Output register, loaded once per set
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_max_ff   <= stats.max_value;
         rsp_min_ff   <= stats.min_value;
         rsp_mean_ff  <= mean_ff;
         rsp_sd_ff    <= sd_ff;
         rsp_count_ff <= stats.count;
         rsp_ovf_ff   <= stats.overflow;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_max_value    = rsp_max_ff;
   assign rsp_min_value    = rsp_min_ff;
   assign rsp_mean_value   = rsp_mean_ff;
   assign rsp_std_dev      = rsp_sd_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   // A new result comes only from the output-handover state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
      else $error("result raised outside handover");

   // The shared unit is never restarted while it is still working
   a_iter_start: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !sts.busy)
      else $error("shared unit started while busy");

   // A delivered result covers at least one sample, with max not below min
   a_rsp_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample_count != '0) && (rsp_max_value >= rsp_min_value))
      else $error("result count or extremes inconsistent");

endmodule

/* rtl/mmsd_accum.sv */
// ---------------------------------------------------------------------------
// mmsd_accum: running statistics accumulator
// Squares a loaded sample as it is registered, then folds it into count, max, min,
// sum and sum of squares in the next. Samples past MAX_COUNT set overflow.
// ---------------------------------------------------------------------------
module mmsd_accum import mmsd_pkg::*; #(
   parameter int MAX_COUNT = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic                       clear,
   output stats_type                  stats
);

   logic                       upd_ff;
   logic                       upd_in;
   logic signed [SAMPLE_W-1:0] samp_ff;
   logic [SQUARE_W-1:0]        sq_ff;
   logic [SAMPLE_W-1:0]        mag;
   logic [2*SAMPLE_W-1:0]      mag_sq;
   stats_type                  stats_ff;
   stats_type                  stats_in;

   // Square the magnitude of the incoming sample
   assign mag    = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
   assign mag_sq = mag * mag;
   assign upd_in = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_ff <= 1'b0;
      end else begin
         upd_ff <= upd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         samp_ff <= sample;
         sq_ff   <= mag_sq[SQUARE_W-1:0];
      end
   end

   // Fold the squared sample into the running statistics
   always_comb begin
      stats_in = stats_ff;
      if (clear) begin
         stats_in = '0;
      end else if (upd_ff) begin
         if (stats_ff.count < COUNT_W'(MAX_COUNT)) begin
            if (stats_ff.count == '0) begin
               stats_in.max_value = samp_ff;
               stats_in.min_value = samp_ff;
            end else begin
               if (samp_ff > stats_ff.max_value) stats_in.max_value = samp_ff;
               if (samp_ff < stats_ff.min_value) stats_in.min_value = samp_ff;
            end
            stats_in.sum   = stats_ff.sum +
                             {{(SUM_W-SAMPLE_W){samp_ff[SAMPLE_W-1]}}, samp_ff};
            stats_in.sumsq = stats_ff.sumsq + {{(SUMSQ_W-SQUARE_W){1'b0}}, sq_ff};
            stats_in.count = stats_ff.count + 1'b1;
         end else begin
            stats_in.overflow = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stats_ff <= '0;
      end else begin
         stats_ff <= stats_in;
      end
   end

   assign stats = stats_ff;

endmodule

/* rtl/mmsd_iter.sv */
// ---------------------------------------------------------------------------
// mmsd_iter: shared iterative arithmetic unit
// One adder-subtractor reused one step per cycle for shift-add multiply,
// restoring divide and digit-by-digit square root.
// ---------------------------------------------------------------------------
module mmsd_iter import mmsd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  iter_cmd_type      cmd,
   input  logic [DP_W-1:0]   opa_init,
   input  logic [DP_W-1:0]   opb_init,
   output iter_sts_type      sts,
   output logic [DP_W-1:0]   result
);

   logic              busy_ff, busy_in;
   iter_op_type       op_ff, op_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [DP_W-1:0]   acc_ff, acc_in;
   logic [DP_W-1:0]   opa_ff, opa_in;
   logic [DP_W-1:0]   opb_ff, opb_in;
   logic [DP_W-1:0]   sh_div, sh_sqrt, trial;
   logic [DP_W-1:0]   x, y;
   logic              sub;
   logic [DP_W:0]     sum_full;
   logic              carry;
   logic [DP_W-1:0]   sum;

   // Operand shaping for divide and root steps
   assign sh_div  = {acc_ff[DP_W-2:0], opa_ff[DP_W-1]};
   assign sh_sqrt = {acc_ff[DP_W-3:0], opa_ff[DP_W-1 -: 2]};
   assign trial   = {opb_ff[DP_W-3:0], 2'b01};

   // Select adder operands
   always_comb begin
      case (op_ff)
         OP_DIV: begin
            x = sh_div;  y = opb_ff; sub = 1'b1;
         end
         OP_SQRT: begin
            x = sh_sqrt; y = trial;  sub = 1'b1;
         end
         default: begin
            x = acc_ff;  y = opa_ff; sub = 1'b0;
         end
      endcase
   end

   // The shared adder; carry out high on subtract means x >= y
   assign sum_full = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{DP_W{1'b0}}, sub};
   assign carry    = sum_full[DP_W];
   assign sum      = sum_full[DP_W-1:0];

   // Advance one step per cycle
   always_comb begin
      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      opa_in  = opa_ff;
      opb_in  = opb_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         cnt_in  = cmd.steps;
         acc_in  = '0;
         opa_in  = opa_init;
         opb_in  = opb_init;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
            case (op_ff)
               OP_DIV: begin
                  acc_in = carry ? sum : sh_div;
                  opa_in = {opa_ff[DP_W-2:0], carry};
               end
               OP_SQRT: begin
                  acc_in = carry ? sum : sh_sqrt;
                  opb_in = {opb_ff[DP_W-2:0], carry};
                  opa_in = {opa_ff[DP_W-3:0], 2'b00};
               end
               default: begin
                  if (opb_ff[0]) acc_in = sum;
                  opa_in = {opa_ff[DP_W-2:0], 1'b0};
                  opb_in = {1'b0, opb_ff[DP_W-1:1]};
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         op_ff   <= OP_MUL;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         op_ff   <= op_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
   end

   // Report status and pick the result register
   assign sts.busy = busy_ff;
   assign sts.done = busy_ff && (cnt_ff == '0);

   always_comb begin
      case (op_ff)
         OP_DIV:  result = opa_ff;
         OP_SQRT: result = opb_ff;
         default: result = acc_ff;
      endcase
   end

endmodule

/* verif/mmsd_checker.sv */
// ---------------------------------------------------------------------------
// mmsd_checker: result predictor and comparator for min_max_mean_stddev
// Watches both channels of the statistics block. It rebuilds the running
// statistics of each set from the accepted samples, queues the summary that
// the closing sample must produce, and compares every accepted result with
// the oldest queued summary, field by field.
// ---------------------------------------------------------------------------
module mmsd_checker import mmsd_pkg::*; #(
   parameter int MAX_COUNT = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_last,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [SAMPLE_W-1:0] rsp_max_value,
   input  logic signed [SAMPLE_W-1:0] rsp_min_value,
   input  logic signed [SAMPLE_W-1:0] rsp_mean_value,
   input  logic [SAMPLE_W-1:0]        rsp_std_dev,
   input  logic [COUNT_W-1:0]         rsp_sample_count,
   input  logic                       rsp_overflow,
   output int                         fail_count,
   output int                         open_results
);

   typedef struct {
      logic signed [SAMPLE_W-1:0] max_value;
      logic signed [SAMPLE_W-1:0] min_value;
      logic signed [SAMPLE_W-1:0] mean_value;
      logic [SAMPLE_W-1:0]        std_dev;
      logic [COUNT_W-1:0]         sample_count;
      logic                       overflow;
   } set_summary_type;

   // Summaries of closed sets, oldest first
   set_summary_type summary_q[$];

   // Running statistics of the set in progress
   int unsigned                n_taken;
   logic signed [SAMPLE_W-1:0] set_hi;
   logic signed [SAMPLE_W-1:0] set_lo;
   longint                     sum_acc;
   longint unsigned            sumsq_acc;
   logic                       dropped;

   function automatic void clear_set();
      n_taken   = 0;
      set_hi    = '0;
      set_lo    = '0;
      sum_acc   = 0;
      sumsq_acc = 0;
      dropped   = 1'b0;
   endfunction

   // Largest r with r*r <= v, one result bit at a time from the top
   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned r = 0;
      longint unsigned trial;
      for (int b = 31; b >= 0; b--) begin
         trial = r | (64'd1 << b);
         if (trial * trial <= v) begin
            r = trial;
         end
      end
      return r;
   endfunction

   // Fold one sample into the set; close the set on its last mark
   function automatic void take_sample(logic signed [SAMPLE_W-1:0] s, logic last_mark);
      set_summary_type res;
      longint          sv;
      longint          n_signed;
      longint unsigned n;
      longint unsigned mag_sum;
      longint unsigned scaled_sumsq;
      longint unsigned sum_sq;
      longint unsigned spread;
      sv = s;
      if (n_taken < MAX_COUNT) begin
         if (n_taken == 0) begin
            set_hi = s;
            set_lo = s;
         end else begin
            if (s > set_hi) set_hi = s;
            if (s < set_lo) set_lo = s;
         end
         sum_acc   += sv;
         sumsq_acc += sv * sv;
         n_taken++;
      end else begin
         // set too long: ignore the sample, remember it
         dropped = 1'b1;
      end
      if (last_mark) begin
         n            = n_taken;
         n_signed     = n_taken;
         mag_sum      = (sum_acc < 0) ? -sum_acc : sum_acc;
         scaled_sumsq = n * sumsq_acc;
         sum_sq       = mag_sum * mag_sum;
         spread       = (scaled_sumsq > sum_sq) ? scaled_sumsq - sum_sq : 0;
         res.max_value    = set_hi;
         res.min_value    = set_lo;
         res.mean_value   = 16'(sum_acc / n_signed);
         res.std_dev      = 16'(floor_root(spread / (n * n)));
         res.sample_count = 11'(n);
         res.overflow     = dropped;
         summary_q.push_back(res);
         clear_set();
      end
   endfunction

   function automatic void compare_field(string field, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", field, want, got);
         fail_count++;
      end
   endfunction

   // Check results first so a stray result never pairs with a set closed
   // on the same edge
   always @(posedge clock) begin : watch
      set_summary_type want;
      if (reset) begin
         clear_set();
         summary_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (summary_q.size() == 0) begin
               $error("unexpected result transaction: max %0d min %0d mean %0d count %0d",
                      rsp_max_value, rsp_min_value, rsp_mean_value, rsp_sample_count);
               fail_count++;
            end else begin
               want = summary_q.pop_front();
               compare_field("max_value", want.max_value, rsp_max_value);
               compare_field("min_value", want.min_value, rsp_min_value);
               compare_field("mean_value", want.mean_value, rsp_mean_value);
               compare_field("std_dev", want.std_dev, rsp_std_dev);
               compare_field("sample_count", want.sample_count, rsp_sample_count);
               compare_field("overflow", want.overflow, rsp_overflow);
            end
         end
         if (req_valid && req_ready) begin
            take_sample(req_sample, req_last);
         end
      end
      open_results <= summary_q.size();
   end

endmodule

/* verif/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top: regression bench for min_max_mean_stddev
// Sends sets of signed Q8.8 samples: a directed run over the value extremes,
// zero spread, negative sums and truncated means, then random sets of mixed
// value profiles, including one set longer than the block's capacity. Both
// channels stall in random bursts; the checker beside the block predicts and
// compares every result, and this module gives the verdict.
// ---------------------------------------------------------------------------
module tb_top;
   import mmsd_pkg::*;

   localparam int SET_CAPACITY = 1024;
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int RANDOM_ITEMS = 1850;
   localparam int QUIET_ITEMS  = 150;
   localparam int LONG_HOLD    = 600;
   localparam int HOLD_AFTER   = 10;
   localparam int SETTLE_CYCLES = 250;
   localparam int N_DIRECTED   = 20;

   // {last, sample} pairs for the directed run
   localparam logic [SAMPLE_W:0] DIRECTED [N_DIRECTED] = '{
      {1'b1, 16'h7FFF},                                      // single largest
      {1'b1, 16'h8000},                                      // single smallest
      {1'b1, 16'h0000},                                      // single zero
      {1'b0, 16'h7FFF}, {1'b1, 16'h8000},                    // widest spread
      {1'b0, 16'h8000}, {1'b0, 16'h8000}, {1'b1, 16'h8000},  // large negative sum
      {1'b0, 16'hFFFF}, {1'b1, 16'hFFFE},                    // mean truncates up
      {1'b0, 16'h0001}, {1'b1, 16'h0002},                    // mean truncates down
      {1'b0, 16'h0100}, {1'b0, 16'h0300}, {1'b0, 16'hFB00}, {1'b1, 16'h7FFF},
      {1'b0, 16'h0505}, {1'b0, 16'h0505}, {1'b0, 16'h0505}, {1'b1, 16'h0505}
   };

   typedef enum int {
      FULL_RANGE,
      FULL_SCALE,
      EXTREMES,
      NEAR_ZERO,
      NARROW_BAND
   } value_profile_type;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       req_last   = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready  = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_max_value;
   logic signed [SAMPLE_W-1:0] rsp_min_value;
   logic signed [SAMPLE_W-1:0] rsp_mean_value;
   logic [SAMPLE_W-1:0]        rsp_std_dev;
   logic [COUNT_W-1:0]         rsp_sample_count;
   logic                       rsp_overflow;

   int          fail_count;
   int          open_results;
   bit          quiet      = 1'b0;
   int unsigned gap_chance = 0;
   int unsigned cycles     = 0;

   min_max_mean_stddev #(
      .MAX_COUNT(SET_CAPACITY)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_max_value    (rsp_max_value),
      .rsp_min_value    (rsp_min_value),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_std_dev      (rsp_std_dev),
      .rsp_sample_count (rsp_sample_count),
      .rsp_overflow     (rsp_overflow)
   );

   mmsd_checker #(
      .MAX_COUNT(SET_CAPACITY)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample       (req_sample),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_max_value    (rsp_max_value),
      .rsp_min_value    (rsp_min_value),
      .rsp_mean_value   (rsp_mean_value),
      .rsp_std_dev      (rsp_std_dev),
      .rsp_sample_count (rsp_sample_count),
      .rsp_overflow     (rsp_overflow),
      .fail_count       (fail_count),
      .open_results     (open_results)
   );

   always #4 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side: random stall bursts, one long hold-off once results flow
   initial begin : result_side
      int unsigned seen;
      bit          held;
      seen = 0;
      held = 1'b0;
      forever begin
         if (!held && seen >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
            if (rsp_valid) seen++;
         end
      end
   end

   function automatic logic signed [SAMPLE_W-1:0] pick_sample(value_profile_type profile);
      case (profile)
         FULL_SCALE: begin
            return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         end
         EXTREMES: begin
            case ($urandom_range(0, 5))
               0: return 16'sh7FFF;
               1: return 16'sh8000;
               2: return 16'sh0000;
               3: return 16'sh0001;
               4: return 16'sh7FFE;
               default: return 16'shFFFF;
            endcase
         end
         NEAR_ZERO: begin
            return 16'($urandom_range(0, 1023)) - 16'sd512;
         end
         NARROW_BAND: begin
            return 16'($urandom_range(0, 7)) + 16'sh1200;
         end
         default: begin
            return 16'($urandom);
         end
      endcase
   endfunction

   // Offer one sample transaction, with a random idle burst ahead of it
   task automatic offer(input logic signed [SAMPLE_W-1:0] s, input logic mark);
      if (!quiet && $urandom_range(1, 100) <= gap_chance) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      req_last   <= mark;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_set(input int unsigned len, input value_profile_type profile);
      for (int unsigned i = 1; i <= len; i++) begin
         offer(pick_sample(profile), i == len);
      end
   endtask

   // Stop sending and hold until every closed set has reported
   task automatic await_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_results != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      int unsigned       sent;
      int unsigned       len;
      bit                long_done;
      value_profile_type profile;
      sent      = 0;
      long_done = 1'b0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed run
      gap_chance = 30;
      for (int i = 0; i < N_DIRECTED; i++) begin
         offer(DIRECTED[i][SAMPLE_W-1:0], DIRECTED[i][SAMPLE_W]);
      end
      await_results();

      // Random sets, one of them past capacity
      while (sent < RANDOM_ITEMS) begin
         if (sent >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         case ($urandom_range(0, 2))
            0: gap_chance = 0;
            1: gap_chance = 12;
            default: gap_chance = 50;
         endcase
         if (!long_done && sent >= 300) begin
            long_done = 1'b1;
            len       = SET_CAPACITY + $urandom_range(1, 6);
            profile   = value_profile_type'($urandom_range(0, 1));
         end else begin
            len     = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48)
                                                  : $urandom_range(1, 8);
            profile = value_profile_type'($urandom_range(0, 4));
         end
         send_set(len, profile);
         sent += len;
         if (len > SET_CAPACITY) await_results();
      end

      await_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
